>>> rtl/core/pbft_pkg.sv
package pbft_pkg;

  // Default sizes for the frame table.
  localparam int unsigned FRAMES_DEFAULT   = 16;
  localparam int unsigned PIN_BITS_DEFAULT = 16;

  // Request commands.
  localparam logic [0:0] CMD_FETCH = 1'b0;
  localparam logic [0:0] CMD_UNPIN = 1'b1;

  // Response status codes.
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_UNPINNED  = 3'd3;
  localparam logic [2:0] ST_UNTRACKED = 3'd4;

  // One request item.
  typedef struct packed {
    logic [0:0]  command;
    logic [31:0] page_number;
    logic        mark_dirty;
  } req_t;

  // One response item.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_index;
    logic        disk_read;
    logic [15:0] pin_level;
  } rsp_t;

endpackage

>>> rtl/core/page_buffer_frame_table_unit.sv
// Frame table of a page buffer pool.
// The request channel (req_valid, req_stall, req) carries fetch and unpin
// commands with a page number and a dirty mark. The response channel
// (rsp_valid, rsp_stall, rsp) returns exactly one item per request: status,
// frame index, disk-read request and the pin count after the operation.
// A transfer happens on a rising edge with valid high and stall low.
// Each request is held in an input register, looked up against every frame
// tag in parallel, and the frame entry is updated as the result is written
// into the output register, so a response passes through both registers
// after its transfer, and one request is taken every cycle while req_stall
// is low. The compare-and-update of one frame entry sets that rate.
// Reset clears the valid, pin and dirty bits of all frames and the free frame
// counter; tags need no clearing as they are only read in valid
// frames. When the receiver stalls, the response holds still, the input
// register still drains once into a free output register, and req_stall rises
// only when both registers are full.
module page_buffer_frame_table_unit #(
  parameter int unsigned FRAMES   = pbft_pkg::FRAMES_DEFAULT,
  parameter int unsigned PIN_BITS = pbft_pkg::PIN_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pbft_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pbft_pkg::rsp_t rsp
);

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);

  // Pipeline registers.
  logic           req_full;
  pbft_pkg::req_t req_q;
  logic           rsp_full;
  pbft_pkg::rsp_t rsp_q;
  logic           advance;

  // Frame table state.
  logic [31:0]         frame_tag   [FRAMES];
  logic [FRAMES-1:0]   frame_valid;
  logic [PIN_BITS-1:0] frame_pins  [FRAMES];
  logic [FRAMES-1:0]   frame_dirty;
  logic [CNT_W-1:0]    next_free;

  // Lookup and update signals.
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                pool_full;
  logic [IDX_W-1:0]    free_idx;
  logic [PIN_BITS-1:0] hit_pins;
  logic [PIN_BITS-1:0] pins_next;
  logic                wr_pins;
  logic                wr_alloc;
  logic                wr_dirty;
  logic [IDX_W-1:0]    wr_idx;
  logic [2:0]          st_next;
  logic [31:0]         idx_wide;
  logic [31:0]         pins_wide;
  pbft_pkg::rsp_t      rsp_next;

  // Handshake: the input register moves on when the output register is free
  // or is being emptied this cycle.
  assign advance   = req_full && (!rsp_full || !rsp_stall);
  assign req_stall = req_full && !advance;
  assign rsp_valid = rsp_full;
  assign rsp       = rsp_q;

  // Parallel tag compare; the lowest matching frame wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (frame_valid[k] && (frame_tag[k] == req_q.page_number)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign pool_full = (next_free == CNT_W'(FRAMES));
  assign free_idx  = next_free[IDX_W-1:0];
  assign hit_pins  = frame_pins[hit_idx];

  // Decide the outcome of the request and the single entry it changes.
  always_comb begin
    wr_pins   = 1'b0;
    wr_alloc  = 1'b0;
    wr_dirty  = 1'b0;
    wr_idx    = hit_idx;
    pins_next = hit_pins;
    st_next   = pbft_pkg::ST_UNTRACKED;
    unique case (req_q.command)
      pbft_pkg::CMD_FETCH: begin
        if (hit) begin
          st_next = pbft_pkg::ST_HIT;
          wr_pins = 1'b1;
          if (hit_pins != {PIN_BITS{1'b1}}) begin
            pins_next = hit_pins + PIN_BITS'(1);
          end
        end else if (pool_full) begin
          st_next = pbft_pkg::ST_FULL;
        end else begin
          st_next   = pbft_pkg::ST_LOADED;
          wr_alloc  = 1'b1;
          wr_idx    = free_idx;
          pins_next = PIN_BITS'(1);
        end
      end
      pbft_pkg::CMD_UNPIN: begin
        if (hit) begin
          st_next  = pbft_pkg::ST_UNPINNED;
          wr_pins  = 1'b1;
          wr_dirty = 1'b1;
          if (hit_pins != '0) begin
            pins_next = hit_pins - PIN_BITS'(1);
          end
        end
      end
      default: begin
        st_next = pbft_pkg::ST_UNTRACKED;
      end
    endcase
  end

  // Build the response; index, pin and disk-read fields are zero for full and untracked outcomes.
  always_comb begin
    idx_wide  = 32'(wr_idx);
    pins_wide = 32'(pins_next);
    rsp_next  = '0;
    rsp_next.status = st_next;
    if (wr_pins || wr_alloc) begin
      rsp_next.frame_index = idx_wide[3:0];
      rsp_next.pin_level   = pins_wide[15:0];
    end
    rsp_next.disk_read = wr_alloc;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (advance) begin
      rsp_full <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp_next;
    end
  end

  // Frame control state, written once per transfer that moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      frame_dirty <= '0;
      next_free   <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        frame_pins[k] <= '0;
      end
    end else if (advance) begin
      if (wr_alloc) begin
        frame_valid[wr_idx] <= 1'b1;
        frame_dirty[wr_idx] <= 1'b0;
        next_free           <= next_free + CNT_W'(1);
      end
      if (wr_dirty) begin
        frame_dirty[wr_idx] <= frame_dirty[wr_idx] | req_q.mark_dirty;
      end
      if (wr_pins || wr_alloc) begin
        frame_pins[wr_idx] <= pins_next;
      end
    end
  end

  // Tags carry no reset; they are read only in valid frames.
  always_ff @(posedge clk) begin
    if (advance && wr_alloc) begin
      frame_tag[wr_idx] <= req_q.page_number;
    end
  end

  // The free counter never passes the number of frames.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= CNT_W'(FRAMES))
    else $error("free frame counter beyond pool size");

  // Frames are handed out in order and never returned.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(frame_valid) == 32'(next_free))
    else $error("valid frames disagree with free frame counter");

  // A pool-full response is only given once every frame has been taken.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_full && (rsp_q.status == pbft_pkg::ST_FULL) |-> pool_full)
    else $error("pool full reported with frames still free");

  // A new allocation never lands on a frame that is already in use.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    advance && wr_alloc |-> !frame_valid[wr_idx])
    else $error("allocation onto a valid frame");

  // After a transfer moves on, the output register holds an item.
  a_rsp_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_full)
    else $error("response lost after lookup");

endmodule
